// ----- src/pmm_pkg.sv -----
// shared types and constants for the paged memory manager
`timescale 1ns / 1ps
package pmm_pkg;
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_t;
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_NOMEM    = 2'd2
    } status_t;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 8;
    localparam int BREAK_W  = 17;
    localparam int SIZE_W   = 17;
    localparam int PROC_W   = 2;
    localparam logic [BREAK_W-1:0] START_BREAK_RESET = 17'd256;
endpackage

// ----- src/paged_memory_manager.sv -----
// top level of the paged memory manager
//
// input channel in_valid/in_stall carries one request transaction (cmd,
// process, address, size, write_data); output channel out_valid/out_stall
// carries one result transaction (status, base_address, read_data) per request.
// the configuration channel cfg_valid/cfg_ready writes start_break, which
// reloads every process break pointer; it is taken only while idle, and a
// pending configuration write holds off new requests.
// one request at a time: allocate makes a count pass and an assign pass over
// the page owner table, free looks up the mapping and then walks the chained
// pages one by one, read and write look up the mapping and then access the
// byte store; the page owner scan and single-port page tables shape these steps.
// after reset a clearing pass zeroes byte store, page map and owner table,
// with no request accepted meanwhile.
// a stalled result holds and no new request is taken until it leaves.
`timescale 1ns / 1ps
module paged_memory_manager #(
    parameter int OFFSET_BITS = 8,
    parameter int ADDR_BITS   = 16,
    parameter int PHYS_PAGES  = 256,
    parameter int PROCS       = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [pmm_pkg::CMD_W-1:0]    cmd,
    input  logic [pmm_pkg::PROC_W-1:0]   process,
    input  logic [ADDR_BITS-1:0]         address,
    input  logic [pmm_pkg::SIZE_W-1:0]   size,
    input  logic [pmm_pkg::DATA_W-1:0]   write_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pmm_pkg::STATUS_W-1:0] status,
    output logic [pmm_pkg::BREAK_W-1:0]  base_address,
    output logic [pmm_pkg::DATA_W-1:0]   read_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pmm_pkg::BREAK_W-1:0]  cfg_data
);
    import pmm_pkg::*;
    pmm_core #(
        .OFFSET_BITS(OFFSET_BITS), .ADDR_BITS(ADDR_BITS),
        .PHYS_PAGES(PHYS_PAGES), .PROCS(PROCS)
    ) u_core (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .process(process), .address(address), .size(size),
        .write_data(write_data), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .base_address(base_address), .read_data(read_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );
endmodule

// ----- src/pmm_core.sv -----
// sequencer, page tables and byte store of the paged memory manager
`timescale 1ns / 1ps
module pmm_core #(
    parameter int OFFSET_BITS = 8,
    parameter int ADDR_BITS   = 16,
    parameter int PHYS_PAGES  = 256,
    parameter int PROCS       = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pmm_pkg::CMD_W-1:0]   cmd,
    input  logic [pmm_pkg::PROC_W-1:0]  process,
    input  logic [ADDR_BITS-1:0]        address,
    input  logic [pmm_pkg::SIZE_W-1:0]  size,
    input  logic [pmm_pkg::DATA_W-1:0]  write_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pmm_pkg::STATUS_W-1:0] status,
    output logic [pmm_pkg::BREAK_W-1:0] base_address,
    output logic [pmm_pkg::DATA_W-1:0]  read_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pmm_pkg::BREAK_W-1:0] cfg_data
);
    import pmm_pkg::*;
    localparam int PPW   = $clog2(PHYS_PAGES);
    localparam int VPW   = ADDR_BITS - OFFSET_BITS;
    localparam int VPGS  = 1 << VPW;
    localparam int PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int MAPW  = PW + VPW;
    localparam int MAPD  = PROCS * VPGS;
    localparam int MEMD  = PHYS_PAGES << OFFSET_BITS;
    localparam int MEMW  = PPW + OFFSET_BITS;
    localparam int CNTW  = PPW + 1;
    localparam int EXTW  = ADDR_BITS + 2;
    localparam int OWNW  = $clog2(PROCS + 1);
    localparam int CLRD  = (MEMD > MAPD) ? MEMD : MAPD;
    localparam int CLRW  = $clog2(CLRD) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_COUNT, S_ALLOC, S_LOOK, S_LOOK2,
        S_FREE, S_FREE2, S_READ, S_READ2, S_OUT
    } state_t;

    // memories
    logic [DATA_W-1:0] mem [MEMD];
    logic [OWNW-1:0]   owner [PHYS_PAGES];
    logic [PPW:0]      chain [PHYS_PAGES];
    logic [PPW:0]      pmap [MAPD];
    logic [BREAK_W-1:0] brk [PROCS];

    state_t state_reg;
    logic [CLRW-1:0]    clr_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [PW-1:0]      proc_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [DATA_W-1:0]  wd_reg;
    logic [CNTW-1:0]    need_reg, free_reg, done_reg;
    logic [CNTW-1:0]    idx_reg;
    logic [PPW-1:0]     prev_reg, ppg_reg;
    logic               have_prev_reg;
    logic [VPW:0]       vpn_reg;
    logic [BREAK_W-1:0] bp_reg;
    logic [OWNW-1:0]    own_q;
    logic [PPW:0]       map_q, chain_q;
    logic [DATA_W-1:0]  mem_q;
    logic [STATUS_W-1:0] status_reg;
    logic [BREAK_W-1:0] base_reg;
    logic [DATA_W-1:0]  rd_reg;

    logic [SIZE_W-1:0] npages;
    logic [EXTW-1:0]   vend;
    logic [PPW-1:0]    idx_lo;
    logic [MAPW-1:0]   map_at_addr;

    assign npages = SIZE_W'(((SIZE_W+1)'(size) + (SIZE_W+1)'((1 << OFFSET_BITS) - 1))
                            >> OFFSET_BITS);
    assign vend = EXTW'(bp_reg) + (EXTW'(need_reg) << OFFSET_BITS);
    assign idx_lo = idx_reg[PPW-1:0];
    assign map_at_addr = {proc_reg, addr_reg[ADDR_BITS-1:OFFSET_BITS]};

    assign in_stall     = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign status       = status_reg;
    assign base_address = base_reg;
    assign read_data    = rd_reg;

    always_ff @(posedge clk)
    begin
        own_q   <= owner[idx_lo];
        chain_q <= chain[ppg_reg];
        mem_q   <= mem[{ppg_reg, addr_reg[OFFSET_BITS-1:0]}];
        if (state_reg == S_FREE)
            map_q <= pmap[{proc_reg, vpn_reg[VPW-1:0]}];
        else
            map_q <= pmap[map_at_addr];
        if (state_reg == S_CLEAR)
        begin
            if (clr_reg < CLRW'(MEMD))
                mem[clr_reg[MEMW-1:0]] <= '0;
            if (clr_reg < CLRW'(MAPD))
                pmap[clr_reg[MAPW-1:0]] <= '0;
            if (clr_reg < CLRW'(PHYS_PAGES))
                owner[clr_reg[PPW-1:0]] <= '0;
        end
        else if (state_reg == S_ALLOC && idx_reg > CNTW'(0) && own_q == '0
                 && done_reg < need_reg)
        begin
            owner[prev_reg] <= OWNW'(proc_reg) + OWNW'(1);
            chain[prev_reg] <= {1'b1, {PPW{1'b0}}};
            pmap[{proc_reg, VPW'(vpn_reg + (VPW+1)'(done_reg))}] <= {1'b1, prev_reg};
        end
        else if (state_reg == S_FREE2 && map_q == {1'b1, ppg_reg})
        begin
            pmap[{proc_reg, vpn_reg[VPW-1:0]}] <= '0;
            owner[ppg_reg] <= '0;
        end
        else if (state_reg == S_READ && cmd_reg == CMD_WRITE)
            mem[{ppg_reg, addr_reg[OFFSET_BITS-1:0]}] <= wd_reg;
        if (state_reg == S_ALLOC && have_prev_reg && idx_reg > CNTW'(0) && own_q == '0
            && done_reg < need_reg)
            chain[ppg_reg] <= {1'b0, prev_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < PROCS; i++)
                brk[i] <= START_BREAK_RESET;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLRW'(1);
                    if (clr_reg == CLRW'(CLRD - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        for (int i = 0; i < PROCS; i++)
                            brk[i] <= cfg_data;
                    end
                    else if (in_valid)
                    begin
                        cmd_reg    <= cmd;
                        proc_reg   <= PW'(process);
                        addr_reg   <= address;
                        wd_reg     <= write_data;
                        status_reg <= ST_OK;
                        base_reg   <= '0;
                        rd_reg     <= '0;
                        idx_reg    <= '0;
                        free_reg   <= '0;
                        done_reg   <= '0;
                        have_prev_reg <= 1'b0;
                        need_reg   <= (npages > SIZE_W'(PHYS_PAGES)) ? CNTW'(PHYS_PAGES + 1)
                                                                     : CNTW'(npages);
                        if (32'(process) >= PROCS)
                        begin
                            status_reg <= (cmd_t'(cmd) == CMD_ALLOC) ? ST_NOMEM : ST_UNMAPPED;
                            state_reg  <= S_OUT;
                        end
                        else if (cmd_t'(cmd) == CMD_ALLOC)
                        begin
                            bp_reg <= brk[PW'(process)];
                            if (npages == '0)
                            begin
                                status_reg <= ST_NOMEM;
                                state_reg  <= S_OUT;
                            end
                            else
                                state_reg <= S_COUNT;
                        end
                        else
                            state_reg <= S_LOOK;
                    end
                end
                S_COUNT:
                begin
                    // own_q is registered from owner[idx], so it holds the entry for idx - 1
                    idx_reg <= idx_reg + CNTW'(1);
                    if (idx_reg > CNTW'(0) && own_q == '0)
                        free_reg <= free_reg + CNTW'(1);
                    if (idx_reg == CNTW'(PHYS_PAGES))
                    begin
                        idx_reg <= '0;
                        if ((free_reg + CNTW'(own_q == '0)) < need_reg
                            || vend > (EXTW'(1) << ADDR_BITS))
                        begin
                            status_reg <= ST_NOMEM;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            vpn_reg   <= (VPW+1)'(bp_reg >> OFFSET_BITS);
                            state_reg <= S_ALLOC;
                        end
                    end
                end
                S_ALLOC:
                begin
                    idx_reg  <= idx_reg + CNTW'(1);
                    prev_reg <= idx_lo;
                    if (idx_reg > CNTW'(0) && own_q == '0 && done_reg < need_reg)
                    begin
                        done_reg      <= done_reg + CNTW'(1);
                        ppg_reg       <= prev_reg;
                        have_prev_reg <= 1'b1;
                    end
                    if (idx_reg == CNTW'(PHYS_PAGES))
                    begin
                        base_reg  <= bp_reg;
                        brk[proc_reg] <= BREAK_W'(vend);
                        state_reg <= S_OUT;
                    end
                end
                S_LOOK:
                    state_reg <= S_LOOK2;
                S_LOOK2:
                begin
                    if (!map_q[PPW] || 32'(map_q[PPW-1:0]) >= PHYS_PAGES)
                    begin
                        status_reg <= ST_UNMAPPED;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        ppg_reg   <= map_q[PPW-1:0];
                        vpn_reg   <= {1'b0, addr_reg[ADDR_BITS-1:OFFSET_BITS]};
                        idx_reg   <= '0;
                        state_reg <= (cmd_reg == CMD_FREE) ? S_FREE : S_READ;
                    end
                end
                S_FREE:
                    state_reg <= S_FREE2;
                S_FREE2:
                begin
                    idx_reg <= idx_reg + CNTW'(1);
                    if (map_q != {1'b1, ppg_reg} || chain_q[PPW]
                        || idx_reg == CNTW'(PHYS_PAGES - 1)
                        || vpn_reg == (VPW+1)'(VPGS - 1)
                        || 32'(chain_q[PPW-1:0]) >= PHYS_PAGES)
                        state_reg <= S_OUT;
                    else
                    begin
                        ppg_reg   <= chain_q[PPW-1:0];
                        vpn_reg   <= vpn_reg + (VPW+1)'(1);
                        state_reg <= S_FREE;
                    end
                end
                S_READ:
                    state_reg <= S_READ2;
                S_READ2:
                begin
                    // byte store read data is registered, arriving the cycle after its address
                    if (cmd_reg == CMD_READ)
                        rd_reg <= mem_q;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- src/pmm_checker.sv -----
// port-level checks for the paged memory manager
`timescale 1ns / 1ps
module pmm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [7:0] read_data,
    input logic       cfg_ready
);
    import pmm_pkg::*;
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while busy");
    a_no_take_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while result pending");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("bad status code");
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (read_data == '0))
        else $error("data on failed request");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !out_valid)
        else $error("config ready while busy");
endmodule

bind paged_memory_manager pmm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .read_data(read_data), .cfg_ready(cfg_ready)
);
